[hw/rtl/rn_pkg.sv]
// shared types, constants and symbol tables for the roman numeral encoder
// no dependencies; the front, back, top-level and checker files take names from here by scope
`timescale 1ns / 1ps

package rn_pkg;

  // largest value that has a numeral
  localparam logic [11:0] MAX_VALUE = 12'd3999;

  // ascii codes of the seven symbols
  localparam logic [6:0] SYM_I = 7'h49;
  localparam logic [6:0] SYM_V = 7'h56;
  localparam logic [6:0] SYM_X = 7'h58;
  localparam logic [6:0] SYM_L = 7'h4C;
  localparam logic [6:0] SYM_C = 7'h43;
  localparam logic [6:0] SYM_D = 7'h44;
  localparam logic [6:0] SYM_M = 7'h4D;

  // decimal positions, units upward
  localparam logic [1:0] POS_UNITS     = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  // four bcd digits, index is the decimal position
  typedef logic [3:0][3:0] digits_t;
  localparam int DigitsWidth = 16;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPLIT,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // digit times the weight of its position
  function automatic logic [13:0] rn_multiple(logic [1:0] pos, logic [3:0] d);
    logic [13:0] m;
    m = 14'd0;
    case (pos)
      POS_THOUSANDS: m = 14'(d) * 14'd1000;
      POS_HUNDREDS:  m = 14'(d) * 14'd100;
      POS_TENS:      m = 14'(d) * 14'd10;
      default:       m = 14'(d);
    endcase
    return m;
  endfunction

  // one symbol of a position
  function automatic logic [6:0] rn_one(logic [1:0] pos);
    logic [6:0] s;
    s = SYM_I;
    case (pos)
      POS_UNITS:    s = SYM_I;
      POS_TENS:     s = SYM_X;
      POS_HUNDREDS: s = SYM_C;
      default:      s = SYM_M;
    endcase
    return s;
  endfunction

  // five symbol of a position; thousands has none
  function automatic logic [6:0] rn_five(logic [1:0] pos);
    logic [6:0] s;
    s = SYM_V;
    case (pos)
      POS_UNITS:    s = SYM_V;
      POS_TENS:     s = SYM_L;
      POS_HUNDREDS: s = SYM_D;
      default:      s = SYM_M;
    endcase
    return s;
  endfunction

  // number of characters one digit expands to
  function automatic logic [2:0] rn_run_len(logic [3:0] d);
    logic [2:0] n;
    n = 3'd0;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // k-th character of the run for digit d at position pos
  function automatic logic [6:0] rn_run_sym(logic [1:0] pos, logic [3:0] d,
                                            logic [1:0] k);
    logic [6:0] s;
    s = rn_one(pos);
    if (d == 4'd4) begin
      s = (k == 2'd0) ? rn_one(pos) : rn_five(pos);
    end else if (d == 4'd9) begin
      s = (k == 2'd0) ? rn_one(pos) : rn_one(pos + 2'd1);
    end else if (d >= 4'd5) begin
      s = (k == 2'd0) ? rn_five(pos) : rn_one(pos);
    end
    return s;
  endfunction

endpackage

[hw/rtl/rn_in_if.sv]
// input channel: one unsigned value per beat
// no dependencies
`timescale 1ns / 1ps

interface rn_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[hw/rtl/rn_out_if.sv]
// output channel: one numeral character per beat
// no dependencies
`timescale 1ns / 1ps

interface rn_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

[hw/rtl/rn_front.sv]
// front end: accepts a value, drops zero and out-of-range, splits into bcd digits
// depends on rn_pkg and rn_in_if
`timescale 1ns / 1ps

module rn_front (
  input  logic             clk,
  input  logic             rst,
  rn_in_if.sink            number,
  output logic             push,
  output rn_pkg::digits_t  push_digits,
  input  logic             full
);

  rn_pkg::front_state_t state, state_next;
  logic [11:0]          rem, rem_next;
  logic [1:0]           pos, pos_next;
  rn_pkg::digits_t      digits, digits_next;
  logic [3:0]           dig;
  logic [11:0]          rem_sub;

  assign number.ready = (state == rn_pkg::F_IDLE);
  assign push         = (state == rn_pkg::F_PUSH) && !full;
  assign push_digits  = digits;

  // one digit per cycle: compare against every multiple of the position weight
  always_comb begin
    dig = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (14'(rem) >= rn_pkg::rn_multiple(pos, 4'(k))) begin
        dig = 4'(k);
      end
    end
    rem_sub = 12'(14'(rem) - rn_pkg::rn_multiple(pos, dig));
  end

  // next state
  always_comb begin
    state_next  = state;
    rem_next    = rem;
    pos_next    = pos;
    digits_next = digits;
    case (state)
      rn_pkg::F_IDLE: begin
        if (number.valid) begin
          rem_next = number.value;
          pos_next = rn_pkg::POS_THOUSANDS;
          if (number.value != 12'd0 && number.value <= rn_pkg::MAX_VALUE) begin
            state_next = rn_pkg::F_SPLIT;
          end
        end
      end
      rn_pkg::F_SPLIT: begin
        digits_next[pos] = dig;
        rem_next         = rem_sub;
        pos_next         = pos - 2'd1;
        if (pos == rn_pkg::POS_TENS) begin
          digits_next[rn_pkg::POS_UNITS] = rem_sub[3:0];
          state_next = rn_pkg::F_PUSH;
        end
      end
      rn_pkg::F_PUSH: begin
        if (!full) begin
          state_next = rn_pkg::F_IDLE;
        end
      end
      default: state_next = rn_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rn_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    pos    <= pos_next;
    digits <= digits_next;
  end

endmodule

[hw/rtl/rn_fifo.sv]
// short queue of digit groups between front and back
// depends on nothing
`timescale 1ns / 1ps

module rn_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wptr, rptr;
  logic [CntW-1:0]  count;
  logic             do_push, do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LastPtr) ? '0 : wptr + PtrW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LastPtr) ? '0 : rptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/rn_back.sv]
// back end: walks the digits high to low and emits one character per beat
// depends on rn_pkg and rn_out_if
`timescale 1ns / 1ps

module rn_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  rn_pkg::digits_t  pop_digits,
  output logic             pop,
  rn_out_if.source         numeral
);

  rn_pkg::back_state_t state, state_next;
  rn_pkg::digits_t     digits, digits_next;
  logic [1:0]          pos, pos_next;
  logic [1:0]          k, k_next;
  logic                out_valid, out_valid_next;
  logic [6:0]          out_symbol, out_symbol_next;
  logic                out_last, out_last_next;
  logic [3:0]          cur_d;
  logic [2:0]          cur_len;
  logic                lower_zero;
  logic                out_free;
  logic                emit;
  logic                digit_done;

  assign numeral.valid  = out_valid;
  assign numeral.symbol = out_symbol;
  assign numeral.last   = out_last;

  // current digit and whether every lower digit is zero
  always_comb begin
    cur_d      = digits[pos];
    cur_len    = rn_pkg::rn_run_len(cur_d);
    lower_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < pos && digits[i] != 4'd0) begin
        lower_zero = 1'b0;
      end
    end
    out_free   = !out_valid || numeral.ready;
    emit       = (state == rn_pkg::B_RUN) && (cur_len != 3'd0) && out_free;
    digit_done = (cur_len == 3'd0) || (emit && (3'(k) == cur_len - 3'd1));
  end

  // sequencer and output register
  always_comb begin
    state_next      = state;
    digits_next     = digits;
    pos_next        = pos;
    k_next          = k;
    pop             = 1'b0;
    out_valid_next  = out_valid;
    out_symbol_next = out_symbol;
    out_last_next   = out_last;
    if (numeral.ready) begin
      out_valid_next = 1'b0;
    end
    if (emit) begin
      out_valid_next  = 1'b1;
      out_symbol_next = rn_pkg::rn_run_sym(pos, cur_d, k);
      out_last_next   = digit_done && lower_zero;
    end
    case (state)
      rn_pkg::B_IDLE: begin
        if (!empty) begin
          pop         = 1'b1;
          digits_next = pop_digits;
          pos_next    = rn_pkg::POS_THOUSANDS;
          k_next      = 2'd0;
          state_next  = rn_pkg::B_RUN;
        end
      end
      rn_pkg::B_RUN: begin
        if (digit_done) begin
          k_next = 2'd0;
          if (pos == rn_pkg::POS_UNITS) begin
            state_next = rn_pkg::B_IDLE;
          end else begin
            pos_next = pos - 2'd1;
          end
        end else if (emit) begin
          k_next = k + 2'd1;
        end
      end
      default: state_next = rn_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rn_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    digits     <= digits_next;
    pos        <= pos_next;
    k          <= k_next;
    out_symbol <= out_symbol_next;
    out_last   <= out_last_next;
  end

endmodule

[hw/rtl/integer_to_roman_encoder.sv]
// Converts an unsigned value of 1 to 3999 into its Roman numeral, sent as one
// ASCII character per output beat, most significant digit first, with last set
// on the final character; 0 and values above 3999 are taken and give no output.
// The front end holds an item through accept, three digit-split steps through
// one compare-and-subtract unit and a hand-off into a 2-entry queue, and takes
// no new value until that hand-off is done; 0 and values above 3999 leave it
// idle and can follow back to back. The back end loads a digit group, then
// emits its characters in turn and skips zero digits; the longest numeral has
// fifteen characters. Back-pressure on the output stalls the back end alone;
// the queue keeps the front end going until the queue is full.
// Depends on rn_pkg, rn_in_if, rn_out_if, rn_front, rn_fifo and rn_back.
`timescale 1ns / 1ps

module integer_to_roman_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  rn_in_if.sink    number,
  rn_out_if.source numeral
);

  logic             push, full, pop, empty;
  rn_pkg::digits_t  push_digits, pop_digits;

  rn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .number      (number),
    .push        (push),
    .push_digits (push_digits),
    .full        (full)
  );

  rn_fifo #(
    .WIDTH (rn_pkg::DigitsWidth),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_digits),
    .full  (full),
    .pop   (pop),
    .rdata (pop_digits),
    .empty (empty)
  );

  rn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_digits (pop_digits),
    .pop        (pop),
    .numeral    (numeral)
  );

endmodule

[hw/rtl/rn_checker.sv]
// port-level checks for the roman numeral encoder, bound to the top level
// depends on rn_pkg
`timescale 1ns / 1ps

module rn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [11:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_symbol,
  input logic        out_last
);

  // a held character keeps its valid
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // a held character keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_last))
    else $error("output payload changed while stalled");

  // every character is one of the seven numeral symbols
  a_symbol_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_symbol == rn_pkg::SYM_I || out_symbol == rn_pkg::SYM_V ||
                   out_symbol == rn_pkg::SYM_X || out_symbol == rn_pkg::SYM_L ||
                   out_symbol == rn_pkg::SYM_C || out_symbol == rn_pkg::SYM_D ||
                   out_symbol == rn_pkg::SYM_M))
    else $error("output symbol is not a numeral character");

  // the front end is busy for the cycle after a convertible beat is taken
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_value != 12'd0 && in_value <= rn_pkg::MAX_VALUE
    |=> !in_ready)
    else $error("input taken right after a convertible value");

endmodule

bind integer_to_roman_encoder rn_checker u_rn_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (number.valid),
  .in_ready   (number.ready),
  .in_value   (number.value),
  .out_valid  (numeral.valid),
  .out_ready  (numeral.ready),
  .out_symbol (numeral.symbol),
  .out_last   (numeral.last)
);
